### rtl/edf_pkg.sv
package edf_pkg;

  localparam int TASK_W  = 4;
  localparam int INST_W  = 4;
  localparam int TIME_W  = 32;
  localparam int WORK_W  = 20;
  localparam int CNT_W   = 5;
  localparam int EXEC_W  = 16;
  localparam int NUM_TASKS = 1 << TASK_W;
  localparam int MEM_DEPTH = 1 << (TASK_W + INST_W);

  localparam logic [CNT_W-1:0] TASK_LIMIT = CNT_W'(NUM_TASKS);
  localparam logic [3:0]       FREQ_RESET = 4'd10;

  // ceil(w / 10) = ((w + 9) * RECIP_TEN) >> RECIP_SHIFT, exact for w below 2**20 - 9
  localparam logic [WORK_W-1:0] RECIP_TEN   = 20'd838861;
  localparam int                RECIP_SHIFT = 23;
  localparam logic [WORK_W-1:0] ROUND_UP    = 20'd9;

  localparam logic REG_ACTIVE = 1'b0;
  localparam logic REG_FREQ   = 1'b1;

  typedef enum logic [1:0] {
    ACT_LOAD_TASK = 2'd0,
    ACT_LOAD_EXEC = 2'd1,
    ACT_TICK      = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_READY = 2'd1,
    MODE_RUN   = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REL_RD,
    ST_REL_UPD,
    ST_SEL_A,
    ST_SEL_B,
    ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_TASK,
    OP_LOAD_EXEC,
    OP_START,
    OP_REL_RD,
    OP_REL_UPD,
    OP_SEL_A,
    OP_SEL_B,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [TASK_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

### rtl/edf_periodic_task_scheduler.sv
// Load requests are accepted back to back while no tick is in progress.
// A tick request steps through the active slots (at most 16) twice:
// a read and an update state per slot for release and retire (execution-time memory read),
// then a select and a slack state per slot for deadline selection and slack (multiply by reciprocal of ten).
// A new request is taken while a result waits in the output register.
// Synchronous reset: all tasks idle, time and work zero, freq_tenths 10.
module edf_periodic_task_scheduler import edf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_action,
  input  logic [TASK_W-1:0] in_task_slot,
  input  logic [INST_W-1:0] in_instance_slot,
  input  logic [15:0]       in_period_ticks,
  input  logic [15:0]       in_deadline_ticks,
  input  logic [15:0]       in_first_arrival,
  input  logic [EXEC_W-1:0] in_exec_ticks,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [TIME_W-1:0] out_tick_time,
  output logic              out_run_valid,
  output logic [TASK_W-1:0] out_run_task,
  output logic [TIME_W-1:0] out_slack,
  output logic              out_done_valid,
  output logic [TASK_W-1:0] out_done_task,
  output logic [TIME_W-1:0] out_response_time,
  output logic              out_deadline_missed
);

  logic [CNT_W-1:0] active_r;
  logic [3:0]       freq_r;
  logic             cfg_wr;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_FREQ) ? {28'b0, freq_r} : {27'b0, active_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      freq_r   <= FREQ_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ACTIVE) begin
        active_r <= pwdata[CNT_W-1:0];
      end else begin
        freq_r <= pwdata[3:0];
      end
    end
  end

  edf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_action    (in_action),
    .in_stall     (in_stall),
    .active_tasks (active_r),
    .sts          (sts),
    .cmd          (cmd)
  );

  edf_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .task_slot       (in_task_slot),
    .instance_slot   (in_instance_slot),
    .period_ticks    (in_period_ticks),
    .deadline_ticks  (in_deadline_ticks),
    .first_arrival   (in_first_arrival),
    .exec_ticks      (in_exec_ticks),
    .freq_tenths     (freq_r),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .tick_time       (out_tick_time),
    .run_valid       (out_run_valid),
    .run_task        (out_run_task),
    .slack           (out_slack),
    .done_valid      (out_done_valid),
    .done_task       (out_done_task),
    .response_time   (out_response_time),
    .deadline_missed (out_deadline_missed)
  );

endmodule

### rtl/edf_ctrl.sv
module edf_ctrl import edf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_action,
  output logic             in_stall,
  input  logic [CNT_W-1:0] active_tasks,
  input  dp_sts_t          sts,
  output dp_cmd_t          cmd
);

  state_t            state_r, state_nxt;
  logic [TASK_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]  live_cnt;
  logic              last_slot;

  assign live_cnt  = (active_tasks > TASK_LIMIT) ? TASK_LIMIT : active_tasks;
  assign last_slot = ({1'b0, idx_r} == (live_cnt - CNT_W'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd.op    = OP_NONE;
    cmd.idx   = idx_r;
    in_stall  = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_action)
            ACT_LOAD_TASK: cmd.op = OP_LOAD_TASK;
            ACT_LOAD_EXEC: cmd.op = OP_LOAD_EXEC;
            ACT_TICK: begin
              cmd.op    = OP_START;
              idx_nxt   = '0;
              state_nxt = (live_cnt == '0) ? ST_FIN : ST_REL_RD;
            end
            default: cmd.op = OP_NONE;
          endcase
        end
      end
      ST_REL_RD: begin
        cmd.op    = OP_REL_RD;
        state_nxt = ST_REL_UPD;
      end
      ST_REL_UPD: begin
        cmd.op = OP_REL_UPD;
        if (last_slot) begin
          idx_nxt   = '0;
          state_nxt = ST_SEL_A;
        end else begin
          idx_nxt   = idx_r + TASK_W'(1);
          state_nxt = ST_REL_RD;
        end
      end
      ST_SEL_A: begin
        cmd.op    = OP_SEL_A;
        state_nxt = ST_SEL_B;
      end
      ST_SEL_B: begin
        cmd.op = OP_SEL_B;
        if (last_slot) begin
          state_nxt = ST_FIN;
        end else begin
          idx_nxt   = idx_r + TASK_W'(1);
          state_nxt = ST_SEL_A;
        end
      end
      ST_FIN: begin
        // hold until the result register is free
        if (sts.out_free) begin
          cmd.op    = OP_FINISH;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### rtl/edf_dp.sv
module edf_dp import edf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  input  logic [TASK_W-1:0] task_slot,
  input  logic [INST_W-1:0] instance_slot,
  input  logic [15:0]       period_ticks,
  input  logic [15:0]       deadline_ticks,
  input  logic [15:0]       first_arrival,
  input  logic [EXEC_W-1:0] exec_ticks,
  input  logic [3:0]        freq_tenths,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [TIME_W-1:0] tick_time,
  output logic              run_valid,
  output logic [TASK_W-1:0] run_task,
  output logic [TIME_W-1:0] slack,
  output logic              done_valid,
  output logic [TASK_W-1:0] done_task,
  output logic [TIME_W-1:0] response_time,
  output logic              deadline_missed
);

  mode_t             mode_r   [NUM_TASKS];
  logic [15:0]       period_r [NUM_TASKS];
  logic [15:0]       dl_r     [NUM_TASKS];
  logic [TIME_W-1:0] nrel_r   [NUM_TASKS];
  logic [TIME_W-1:0] due_r    [NUM_TASKS];
  logic [TIME_W-1:0] rel_r    [NUM_TASKS];
  logic [WORK_W-1:0] work_r   [NUM_TASKS];
  logic [INST_W-1:0] inst_r   [NUM_TASKS];
  logic [EXEC_W-1:0] exec_mem [MEM_DEPTH];
  logic [EXEC_W-1:0] exec_q_r;
  logic [TIME_W-1:0] now_r;

  logic              done_ok_r, miss_r, run_ok_r, cand_r, sl_have_r, nr_have_r;
  logic [TASK_W-1:0] done_i_r, run_i_r;
  logic [TIME_W-1:0] resp_r, best_r, d_r, slack_r, nr_min_r;
  logic [WORK_W-1:0] run_work_r;
  logic [2*WORK_W-1:0] prod_r;

  logic              out_valid_r, run_valid_r, done_valid_r, miss_out_r;
  logic [TIME_W-1:0] tick_time_r, slack_out_r, resp_out_r;
  logic [TASK_W-1:0] run_task_r, done_task_r;

  mode_t             cur_mode;
  logic [TIME_W-1:0] cur_nrel, cur_due, cur_rel, d_val, resp_val, nr_gap, s_val, c_ext;
  logic [WORK_W-1:0] cur_work, exec_tenths, work_dec;
  logic [2*WORK_W-1:0] prod_val;
  logic [2*WORK_W-RECIP_SHIFT-1:0] c_val;
  logic              rel_hit, ret_hit, cand, nr_gt;

  assign cur_mode = mode_r[cmd.idx];
  assign cur_nrel = nrel_r[cmd.idx];
  assign cur_due  = due_r[cmd.idx];
  assign cur_rel  = rel_r[cmd.idx];
  assign cur_work = work_r[cmd.idx];

  assign rel_hit  = (cur_mode == MODE_IDLE) && (now_r >= cur_nrel);
  assign ret_hit  = (cur_mode == MODE_RUN) && (cur_work == '0);
  assign cand     = (cur_mode == MODE_READY) || (cur_mode == MODE_RUN);
  assign resp_val = now_r - cur_rel;
  assign d_val    = (cur_due >= now_r) ? (cur_due - now_r) : '0;
  assign nr_gt    = (cur_nrel > now_r);
  assign nr_gap   = cur_nrel - now_r;

  // exec * 10 as exec * 8 + exec * 2
  assign exec_tenths = WORK_W'({exec_q_r, 3'b000}) + WORK_W'({exec_q_r, 1'b0});

  assign prod_val = {{WORK_W{1'b0}}, cur_work + ROUND_UP} * {{WORK_W{1'b0}}, RECIP_TEN};
  assign c_val    = prod_r[2*WORK_W-1:RECIP_SHIFT];
  assign c_ext    = TIME_W'(c_val);
  assign s_val    = (d_r >= c_ext) ? (d_r - c_ext) : '0;

  assign work_dec = (run_work_r >= WORK_W'(freq_tenths)) ?
                    (run_work_r - WORK_W'(freq_tenths)) : '0;

  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD_EXEC) begin
      exec_mem[{task_slot, instance_slot}] <= exec_ticks;
    end
    if (cmd.op == OP_REL_RD) begin
      exec_q_r <= exec_mem[{cmd.idx, inst_r[cmd.idx]}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        mode_r[i] <= MODE_IDLE;
        work_r[i] <= '0;
        inst_r[i] <= '0;
        due_r[i]  <= '0;
        rel_r[i]  <= '0;
      end
      now_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_FINISH) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        OP_LOAD_TASK: begin
          period_r[task_slot] <= period_ticks;
          dl_r[task_slot]     <= deadline_ticks;
          nrel_r[task_slot]   <= TIME_W'(first_arrival);
        end
        OP_START: begin
          done_ok_r <= 1'b0;
          done_i_r  <= '0;
          resp_r    <= '0;
          miss_r    <= 1'b0;
          run_ok_r  <= 1'b0;
          run_i_r   <= '0;
          sl_have_r <= 1'b0;
          nr_have_r <= 1'b0;
        end
        OP_REL_UPD: begin
          if (rel_hit) begin
            mode_r[cmd.idx] <= MODE_READY;
            work_r[cmd.idx] <= exec_tenths;
            due_r[cmd.idx]  <= now_r + TIME_W'(dl_r[cmd.idx]);
            rel_r[cmd.idx]  <= now_r;
            nrel_r[cmd.idx] <= cur_nrel + TIME_W'(period_r[cmd.idx]);
          end else if (ret_hit) begin
            mode_r[cmd.idx] <= MODE_IDLE;
            inst_r[cmd.idx] <= inst_r[cmd.idx] + INST_W'(1);
            if (!done_ok_r) begin
              done_ok_r <= 1'b1;
              done_i_r  <= cmd.idx;
              resp_r    <= resp_val;
              miss_r    <= (now_r > cur_due);
            end
          end
        end
        OP_SEL_A: begin
          d_r    <= d_val;
          prod_r <= prod_val;
          cand_r <= cand;
          // strict compare keeps the lowest slot on ties
          if (cand && (!run_ok_r || (cur_due < best_r))) begin
            run_ok_r   <= 1'b1;
            run_i_r    <= cmd.idx;
            best_r     <= cur_due;
            run_work_r <= cur_work;
          end
          if (nr_gt && (!nr_have_r || (nr_gap < nr_min_r))) begin
            nr_have_r <= 1'b1;
            nr_min_r  <= nr_gap;
          end
        end
        OP_SEL_B: begin
          if (cand_r && (!sl_have_r || (s_val < slack_r))) begin
            sl_have_r <= 1'b1;
            slack_r   <= s_val;
          end
        end
        OP_FINISH: begin
          if (run_ok_r) begin
            mode_r[run_i_r] <= MODE_RUN;
            work_r[run_i_r] <= work_dec;
          end
          now_r        <= now_r + TIME_W'(1);
          tick_time_r  <= now_r;
          run_valid_r  <= run_ok_r;
          run_task_r   <= run_i_r;
          slack_out_r  <= sl_have_r ? slack_r : (nr_have_r ? nr_min_r : '1);
          done_valid_r <= done_ok_r;
          done_task_r  <= done_i_r;
          resp_out_r   <= resp_r;
          miss_out_r   <= done_ok_r && miss_r;
        end
        default: ;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign tick_time       = tick_time_r;
  assign run_valid       = run_valid_r;
  assign run_task        = run_task_r;
  assign slack           = slack_out_r;
  assign done_valid      = done_valid_r;
  assign done_task       = done_task_r;
  assign response_time   = resp_out_r;
  assign deadline_missed = miss_out_r;

endmodule
